FILE: rtl/hwc_pkg.sv
`default_nettype none

package hwc_pkg;

    localparam int DRY_W  = 10;
    localparam int TIME_W = 32;
    localparam int CMD_W  = 2;

    // item kinds carried in s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_EVAL   = 2'd1,
        CMD_PUMP   = 2'd2
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_DRY    = 2'd0;
    localparam logic [1:0] REG_WET    = 2'd1;
    localparam logic [1:0] REG_MIN_MS = 2'd2;

    localparam logic [DRY_W-1:0]  RST_DRY    = 10'd500;
    localparam logic [DRY_W-1:0]  RST_WET    = 10'd350;
    localparam logic [TIME_W-1:0] RST_MIN_MS = 32'd180000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PUSH,
        ST_DIV,
        ST_EVAL,
        ST_PUMP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [DRY_W-1:0]  dry;
        logic [DRY_W-1:0]  wet;
        logic [TIME_W-1:0] min_ms;
    } cfg_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic capture;
        logic read_old;
        logic push;
        logic div_step;
        logic eval;
        logic pump;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/hwc_ctrl.sv
`default_nettype none

module hwc_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [hwc_pkg::CMD_W-1:0]   in_cmd,
    output logic                             in_ready,
    input  wire hwc_pkg::dp_stat_t           stat,
    output hwc_pkg::dp_cmd_t                 cmd
);

    hwc_pkg::state_t state_reg;
    hwc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hwc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hwc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (hwc_pkg::cmd_t'(in_cmd))
                        hwc_pkg::CMD_SAMPLE: state_next = hwc_pkg::ST_READ;
                        hwc_pkg::CMD_EVAL:   state_next = hwc_pkg::ST_EVAL;
                        hwc_pkg::CMD_PUMP:   state_next = hwc_pkg::ST_PUMP;
                        default:             state_next = hwc_pkg::ST_FIN;
                    endcase
                end
            end
            hwc_pkg::ST_READ: state_next = hwc_pkg::ST_PUSH;
            hwc_pkg::ST_PUSH: state_next = hwc_pkg::ST_DIV;
            hwc_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = hwc_pkg::ST_FIN;
                end
            end
            hwc_pkg::ST_EVAL: state_next = hwc_pkg::ST_FIN;
            hwc_pkg::ST_PUMP: state_next = hwc_pkg::ST_FIN;
            hwc_pkg::ST_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = hwc_pkg::ST_IDLE;
                end
            end
            default: state_next = hwc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            hwc_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            hwc_pkg::ST_READ: cmd.read_old = 1'b1;
            hwc_pkg::ST_PUSH: cmd.push     = 1'b1;
            hwc_pkg::ST_DIV:  cmd.div_step = 1'b1;
            hwc_pkg::ST_EVAL: cmd.eval     = 1'b1;
            hwc_pkg::ST_PUMP: cmd.pump     = 1'b1;
            hwc_pkg::ST_FIN:  cmd.out_load = stat.out_free;
            default:          cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/hwc_dp.sv
`default_nettype none

module hwc_dp #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hwc_pkg::dp_cmd_t              cmd,
    output hwc_pkg::dp_stat_t                  stat,
    input  wire hwc_pkg::cfg_t                 cfg,
    input  wire logic [SAMPLE_BITS-1:0]        in_sample,
    input  wire logic [hwc_pkg::TIME_W-1:0]    in_now_ms,
    input  wire logic                          in_pump_request,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic                               out_mode,
    output logic                               out_pump_on,
    output logic [hwc_pkg::DRY_W-1:0]          out_dryness,
    output logic                               out_window_full
);

    localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SW   = SAMPLE_BITS + CW;
    localparam int DCW  = $clog2(SW);
    localparam int CMPW = SW + hwc_pkg::DRY_W;

    // captured item
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic [hwc_pkg::TIME_W-1:0] now_reg;
    logic                       req_reg;

    // window
    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [AW-1:0]          slot_reg;
    logic [CW-1:0]          count_reg;
    logic [SW-1:0]          sum_reg;
    logic                   full;
    logic [SW-1:0]          sum_add;
    logic [SW-1:0]          sum_new;

    // divider: shifts the dividend out and the quotient in
    logic [SW-1:0]  dvd_reg;
    logic [CW-1:0]  rem_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic [CW:0]    trial;
    logic           q_bit;
    logic [CW:0]    trial_diff;
    logic [SW-1:0]  avg_reg;

    // control state
    logic                       mode_reg;
    logic                       pump_reg;
    logic [hwc_pkg::TIME_W-1:0] start_reg;
    logic                       time_done;
    logic [CMPW-1:0]            avg_ext;

    logic                       out_valid_reg;
    logic                       out_mode_reg;
    logic                       out_pump_reg;
    logic [hwc_pkg::DRY_W-1:0]  out_dry_reg;
    logic                       out_full_reg;

    assign full       = (count_reg == CW'(WINDOW_DEPTH));
    assign sum_add    = sum_reg + SW'(sample_reg);
    assign sum_new    = full ? (sum_add - SW'(old_reg)) : sum_add;
    assign trial      = {rem_reg, dvd_reg[SW-1]};
    assign q_bit      = (trial >= {1'b0, count_reg});
    assign trial_diff = trial - {1'b0, count_reg};
    assign avg_ext    = {{hwc_pkg::DRY_W{1'b0}}, avg_reg};
    // wrap below the start time counts as elapsed
    assign time_done  = (now_reg < start_reg) || ((now_reg - start_reg) > cfg.min_ms);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= in_sample;
            now_reg    <= in_now_ms;
            req_reg    <= in_pump_request;
        end
        if (cmd.read_old)
        begin
            old_reg <= ring_mem[slot_reg];
        end
        if (cmd.push)
        begin
            ring_mem[slot_reg] <= sample_reg;
            dvd_reg            <= sum_new;
            rem_reg            <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[SW-2:0], q_bit};
            rem_reg <= q_bit ? trial_diff[CW-1:0] : trial[CW-1:0];
        end
        if (cmd.out_load)
        begin
            out_mode_reg <= mode_reg;
            out_pump_reg <= pump_reg;
            out_dry_reg  <= avg_ext[hwc_pkg::DRY_W-1:0];
            out_full_reg <= full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            div_cnt_reg   <= '0;
            avg_reg       <= '0;
            mode_reg      <= 1'b0;
            pump_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                sum_reg     <= sum_new;
                count_reg   <= full ? count_reg : count_reg + 1'b1;
                slot_reg    <= (slot_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (stat.div_last)
                begin
                    avg_reg <= {dvd_reg[SW-2:0], q_bit};
                end
            end
            if (cmd.eval)
            begin
                if (!mode_reg)
                begin
                    if (avg_ext >= CMPW'(cfg.dry))
                    begin
                        mode_reg  <= 1'b1;
                        pump_reg  <= 1'b1;
                        start_reg <= now_reg;
                    end
                end
                else if ((avg_ext <= CMPW'(cfg.wet)) && time_done)
                begin
                    mode_reg <= 1'b0;
                    pump_reg <= 1'b0;
                end
            end
            if (cmd.pump)
            begin
                pump_reg <= req_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.div_last = (div_cnt_reg == DCW'(SW - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_mode        = out_mode_reg;
    assign out_pump_on     = out_pump_reg;
    assign out_dryness     = out_dry_reg;
    assign out_window_full = out_full_reg;

endmodule

`default_nettype wire

FILE: rtl/hysteresis_watering_controller_unit.sv
// Dryness controller with hysteresis over a moving window of samples.
// Input stream (s_*): one transaction per command. s_tuser holds the command
// (add sample, evaluate, override pump); s_tdata holds sample, now_ms and
// pump_request. Every accepted transaction yields exactly one result on the
// output stream (m_*): mode, pump drive, window average and window-full flag.
// An add-sample item steps through READ, PUSH, the restoring divider that
// retires one quotient bit per cycle, and FIN before m_tvalid rises; evaluate
// and override step through their own state and FIN, an unused command
// through FIN alone. One item is in flight at a time: no new transaction is
// accepted until the last one has left FIN.
// A finished result sits in an output register; a stalled receiver
// (m_tready low) holds it while the next item is accepted and processed, and
// that next item waits for the register to drain before it is published.
// Reset (rst_n low, asynchronous) empties the window, sets waiting mode with
// the pump off and loads the threshold and minimum-time defaults.
// Configuration over APB: 0x0 dry threshold, 0x4 wet threshold,
// 0x8 minimum watering time in ms; write only while the block is idle.
`default_nettype none

module hysteresis_watering_controller_unit #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // command stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata: sample, now_ms[31:0], pump_request, zero pad
    input  wire logic [((SAMPLE_BITS + 33 + 7) / 8) * 8 - 1:0] s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [1:0]            s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata: mode, pump_on, dryness[9:0], window_full, zero pad
    output logic [15:0]                m_tdata
);

    hwc_pkg::cfg_t     cfg_reg;
    hwc_pkg::dp_cmd_t  dp_cmd;
    hwc_pkg::dp_stat_t dp_stat;

    logic                        cfg_wr;
    logic [1:0]                  cfg_idx;
    logic                        r_mode;
    logic                        r_pump;
    logic [hwc_pkg::DRY_W-1:0]   r_dry;
    logic                        r_full;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dry    <= hwc_pkg::RST_DRY;
            cfg_reg.wet    <= hwc_pkg::RST_WET;
            cfg_reg.min_ms <= hwc_pkg::RST_MIN_MS;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                hwc_pkg::REG_DRY:    cfg_reg.dry    <= pwdata[hwc_pkg::DRY_W-1:0];
                hwc_pkg::REG_WET:    cfg_reg.wet    <= pwdata[hwc_pkg::DRY_W-1:0];
                hwc_pkg::REG_MIN_MS: cfg_reg.min_ms <= pwdata;
                default:             ; // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            hwc_pkg::REG_DRY:    prdata = {22'd0, cfg_reg.dry};
            hwc_pkg::REG_WET:    prdata = {22'd0, cfg_reg.wet};
            hwc_pkg::REG_MIN_MS: prdata = cfg_reg.min_ms;
            default:             prdata = '0;
        endcase
    end

    // ---------------- controller ----------------
    hwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // ---------------- datapath: window, divider, mode, output register ------
    hwc_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .cfg             (cfg_reg),
        .in_sample       (s_tdata[SAMPLE_BITS-1:0]),
        .in_now_ms       (s_tdata[SAMPLE_BITS+31:SAMPLE_BITS]),
        .in_pump_request (s_tdata[SAMPLE_BITS+32]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_mode        (r_mode),
        .out_pump_on     (r_pump),
        .out_dryness     (r_dry),
        .out_window_full (r_full)
    );

    assign m_tdata = {3'd0, r_full, r_dry, r_pump, r_mode};

    // ---------------- assertions ----------------
    // a result never shows up the cycle right after an item is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result published one cycle after acceptance");

    // a new result is only published while an item is in flight
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result published with no item in flight");

    // no new item is taken while the divider is running
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.div_step |-> !s_tready)
        else $error("input accepted during division");

    // result register only loads when it is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
